>>> rtl/sbts_pkg.sv
// ----------------------------------------------------------------------------
// sbts_pkg
// Types and constants shared by the smoothed bilinear texture sampler.
// ----------------------------------------------------------------------------
package sbts_pkg;

    // Store geometry and channel depth
    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int CHANNEL_BITS = 16;

    localparam int X_BITS     = $clog2(MAX_WIDTH);
    localparam int Y_BITS     = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = X_BITS + Y_BITS;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int SIZE_W     = 9;
    localparam int CHAN_W     = 16;
    localparam int NUM_CHAN   = 4;
    localparam int TEXEL_W    = CHAN_W * NUM_CHAN;
    localparam int COORD_W    = 17;
    localparam int FRAC_W     = 16;
    localparam int SU_W       = COORD_W + X_BITS;   // u * (size - 1)
    localparam int SV_W       = COORD_W + Y_BITS;
    localparam int SQ_W       = 2 * FRAC_W;         // t * t
    localparam int SS_W       = 50;                 // t * t * (3 - 2t)
    localparam int POLY_W     = 18;                 // 3 - 2t in Q.16
    localparam int MIX_W      = 32;                 // horizontal blend
    localparam int MIXP_W     = 33;
    localparam int ACC_W      = 48;                 // vertical blend

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    typedef logic [X_BITS-1:0]   t_xc;
    typedef logic [Y_BITS-1:0]   t_yc;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [SIZE_W-1:0]   t_size;
    typedef logic [CHAN_W-1:0]   t_chan;
    typedef logic [TEXEL_W-1:0]  t_texel;
    typedef logic [COORD_W-1:0]  t_wt;
    typedef logic [FRAC_W-1:0]   t_frac;
    typedef logic [SU_W-1:0]     t_su;
    typedef logic [SV_W-1:0]     t_sv;
    typedef logic [SQ_W-1:0]     t_sq;
    typedef logic [SS_W-1:0]     t_ss;
    typedef logic [POLY_W-1:0]   t_poly;
    typedef logic [MIX_W-1:0]    t_mix;
    typedef logic [MIXP_W-1:0]   t_mixp;
    typedef logic [ACC_W-1:0]    t_acc;
    typedef logic [FIFO_PTR_W-1:0] t_fptr;
    typedef logic [FIFO_CNT_W-1:0] t_fcnt;

    localparam t_wt   ONE_Q16   = t_wt'(65536);
    localparam t_su   HALF_SU   = t_su'(32768);
    localparam t_sv   HALF_SV   = t_sv'(32768);
    localparam t_poly THREE_Q16 = t_poly'(196608);
    localparam t_ss   RND_SS    = t_ss'(1) << 31;
    localparam t_acc  RND_ACC   = t_acc'(1) << 31;
    localparam t_fcnt FIFO_FULL = t_fcnt'(FIFO_DEPTH);
    localparam t_size MAX_W_SZ  = t_size'(MAX_WIDTH);
    localparam t_size MAX_H_SZ  = t_size'(MAX_HEIGHT);
    localparam t_xc   MAX_X     = t_xc'(MAX_WIDTH - 1);
    localparam t_yc   MAX_Y     = t_yc'(MAX_HEIGHT - 1);

    // Only the top CHANNEL_BITS bits of a channel are kept
    localparam t_chan CHAN_KEEP = ~t_chan'((32'd1 << (CHAN_W - CHANNEL_BITS)) - 32'd1);

    // Register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_MODE   = 2'd2;

    // Transaction kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Filter modes
    localparam logic MODE_NEAREST = 1'b0;
    localparam logic MODE_SMOOTH  = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [7:0]          pixel_x;
        logic [7:0]          pixel_y;
        logic [15:0]         wr_red;
        logic [15:0]         wr_green;
        logic [15:0]         wr_blue;
        logic [15:0]         wr_alpha;
        logic [COORD_W-1:0]  tex_u;
        logic [COORD_W-1:0]  tex_v;
    } t_in_item;

    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
        logic [15:0] out_alpha;
    } t_out_item;

endpackage

>>> rtl/sbts_ram.sv
// ----------------------------------------------------------------------------
// sbts_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module sbts_ram #(
    parameter  int WIDTH  = 64,
    parameter  int DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_q <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_q;

endmodule

>>> rtl/smoothed_bilinear_texture_sampler.sv
// ----------------------------------------------------------------------------
// smoothed_bilinear_texture_sampler
// Texel writes: one per cycle unless a stalled sample holds the pipeline, no result.
// Nearest sample: one per cycle unless the pipeline is held, as when no result queue slot is free.
// Smoothed sample: four reads in turn through the single port of the texel RAM;
// the sequencer takes no new item until the last of them is issued.
// Reset clears the pipeline and result queue and loads 256x256, smoothed mode.
// The texel RAM is not cleared.
// ----------------------------------------------------------------------------
module smoothed_bilinear_texture_sampler (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  sbts_pkg::t_in_item   i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output sbts_pkg::t_out_item  o_data,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [8:0]           i_cfg_data
);

    typedef struct packed {
        logic               kind;
        logic               wr_ok;
        logic               near;
        sbts_pkg::t_texel   texel;
        sbts_pkg::t_xc      px;
        sbts_pkg::t_yc      py;
        sbts_pkg::t_su      su;
        sbts_pkg::t_sv      sv;
    } t_stage_b;

    typedef struct packed {
        logic               kind;
        logic               wr_ok;
        logic               near;
        sbts_pkg::t_texel   texel;
        sbts_pkg::t_xc      x0;
        sbts_pkg::t_xc      x1;
        sbts_pkg::t_yc      y0;
        sbts_pkg::t_yc      y1;
        sbts_pkg::t_frac    fx;
        sbts_pkg::t_frac    fy;
        sbts_pkg::t_sq      ttx;
        sbts_pkg::t_sq      tty;
    } t_stage_c;

    typedef struct packed {
        logic               kind;
        logic               wr_ok;
        logic               near;
        sbts_pkg::t_texel   texel;
        sbts_pkg::t_xc      x0;
        sbts_pkg::t_xc      x1;
        sbts_pkg::t_yc      y0;
        sbts_pkg::t_yc      y1;
        sbts_pkg::t_wt      wx2;
        sbts_pkg::t_wt      wy2;
    } t_stage_d;

    // Travels alongside each RAM read
    typedef struct packed {
        logic               vld;
        logic [1:0]         slot;
        logic               last;
        logic               fill;
        sbts_pkg::t_wt      wx2;
        sbts_pkg::t_wt      wy2;
    } t_rd_tag;

    function automatic sbts_pkg::t_wt f_smooth(input sbts_pkg::t_sq tt,
                                                input sbts_pkg::t_frac t);
        sbts_pkg::t_poly k;
        sbts_pkg::t_ss   prod;
        k    = sbts_pkg::THREE_Q16 - {1'b0, t, 1'b0};
        prod = sbts_pkg::t_ss'(tt) * sbts_pkg::t_ss'(k) + sbts_pkg::RND_SS;
        return prod[32 +: sbts_pkg::COORD_W];
    endfunction

    // Configuration
    sbts_pkg::t_size r_width, r_height;
    logic            r_mode;
    sbts_pkg::t_xc   w_m1;
    sbts_pkg::t_yc   h_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= sbts_pkg::MAX_W_SZ;
            r_height <= sbts_pkg::MAX_H_SZ;
            r_mode   <= sbts_pkg::MODE_SMOOTH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sbts_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                sbts_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                sbts_pkg::CFG_MODE:   r_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective size minus one: zero acts as one, oversize as the maximum
    always_comb begin
        if (r_width == '0) begin
            w_m1 = '0;
        end else if (r_width > sbts_pkg::MAX_W_SZ) begin
            w_m1 = sbts_pkg::MAX_X;
        end else begin
            w_m1 = sbts_pkg::t_xc'(r_width - sbts_pkg::t_size'(1));
        end
        if (r_height == '0) begin
            h_m1 = '0;
        end else if (r_height > sbts_pkg::MAX_H_SZ) begin
            h_m1 = sbts_pkg::MAX_Y;
        end else begin
            h_m1 = sbts_pkg::t_yc'(r_height - sbts_pkg::t_size'(1));
        end
    end

    // Pipeline registers
    logic                r_a_vld, r_b_vld, r_c_vld, r_d_vld;
    sbts_pkg::t_in_item  r_a;
    t_stage_b            r_b, n_b;
    t_stage_c            r_c, n_c;
    t_stage_d            r_d, n_d;
    logic [1:0]          r_phase, n_phase;
    sbts_pkg::t_fcnt     r_credits, r_fcnt;
    sbts_pkg::t_fptr     r_wptr, r_rptr;
    t_rd_tag             r_tag, n_tag;

    logic a_take, b_take, c_take, d_take;
    logic is_write, can_go, d_last, d_done, credit_inc, pop, push;

    // Stage A: clamp and scale the coordinates
    sbts_pkg::t_wt u_c, v_c;

    always_comb begin
        u_c = (r_a.tex_u > sbts_pkg::ONE_Q16) ? sbts_pkg::ONE_Q16 : r_a.tex_u;
        v_c = (r_a.tex_v > sbts_pkg::ONE_Q16) ? sbts_pkg::ONE_Q16 : r_a.tex_v;
        n_b.kind  = r_a.kind;
        n_b.wr_ok = (r_a.pixel_x <= w_m1) && (r_a.pixel_y <= h_m1);
        n_b.near  = (r_mode == sbts_pkg::MODE_NEAREST);
        n_b.texel = {r_a.wr_alpha & sbts_pkg::CHAN_KEEP, r_a.wr_blue & sbts_pkg::CHAN_KEEP,
                     r_a.wr_green & sbts_pkg::CHAN_KEEP, r_a.wr_red & sbts_pkg::CHAN_KEEP};
        n_b.px    = r_a.pixel_x;
        n_b.py    = r_a.pixel_y;
        n_b.su    = sbts_pkg::t_su'(u_c) * sbts_pkg::t_su'(w_m1);
        n_b.sv    = sbts_pkg::t_sv'(v_c) * sbts_pkg::t_sv'(h_m1);
    end

    // Stage B: texel indexes and fractions, square of the fractions
    sbts_pkg::t_su  rnd_x, off_x;
    sbts_pkg::t_sv  rnd_y, off_y;
    sbts_pkg::t_xc  bx, nx;
    sbts_pkg::t_yc  by, ny;
    sbts_pkg::t_frac fx, fy;

    always_comb begin
        rnd_x = r_b.su + sbts_pkg::HALF_SU;
        rnd_y = r_b.sv + sbts_pkg::HALF_SV;
        // half-texel shift back, floored at the first texel
        off_x = (r_b.su >= sbts_pkg::HALF_SU) ? r_b.su - sbts_pkg::HALF_SU : '0;
        off_y = (r_b.sv >= sbts_pkg::HALF_SV) ? r_b.sv - sbts_pkg::HALF_SV : '0;
        bx = off_x[sbts_pkg::FRAC_W +: sbts_pkg::X_BITS];
        by = off_y[sbts_pkg::FRAC_W +: sbts_pkg::Y_BITS];
        nx = (bx < w_m1) ? bx + sbts_pkg::t_xc'(1) : w_m1;
        ny = (by < h_m1) ? by + sbts_pkg::t_yc'(1) : h_m1;
        fx = off_x[sbts_pkg::FRAC_W-1:0];
        fy = off_y[sbts_pkg::FRAC_W-1:0];

        if (r_b.kind == sbts_pkg::KIND_WRITE) begin
            bx = r_b.px;
            by = r_b.py;
        end else if (r_b.near) begin
            bx = rnd_x[sbts_pkg::FRAC_W +: sbts_pkg::X_BITS];
            by = rnd_y[sbts_pkg::FRAC_W +: sbts_pkg::Y_BITS];
            nx = bx;
            ny = by;
            fx = '0;
            fy = '0;
        end

        n_c.kind  = r_b.kind;
        n_c.wr_ok = r_b.wr_ok;
        n_c.near  = r_b.near;
        n_c.texel = r_b.texel;
        n_c.x0    = bx;
        n_c.x1    = nx;
        n_c.y0    = by;
        n_c.y1    = ny;
        n_c.fx    = fx;
        n_c.fy    = fy;
        n_c.ttx   = sbts_pkg::t_sq'(fx) * sbts_pkg::t_sq'(fx);
        n_c.tty   = sbts_pkg::t_sq'(fy) * sbts_pkg::t_sq'(fy);
    end

    // Stage C: smoothstep weights
    always_comb begin
        n_d.kind  = r_c.kind;
        n_d.wr_ok = r_c.wr_ok;
        n_d.near  = r_c.near;
        n_d.texel = r_c.texel;
        n_d.x0    = r_c.x0;
        n_d.x1    = r_c.x1;
        n_d.y0    = r_c.y0;
        n_d.y1    = r_c.y1;
        n_d.wx2   = f_smooth(r_c.ttx, r_c.fx);
        n_d.wy2   = f_smooth(r_c.tty, r_c.fy);
    end

    // Stage D: RAM access sequencer. A sample reserves a result queue slot
    // before its first read, so the blend pipe never has to stall.
    sbts_pkg::t_xc    rd_x;
    sbts_pkg::t_yc    rd_y;
    logic             ram_en;
    sbts_pkg::t_texel ram_q;

    always_comb begin
        is_write   = (r_d.kind == sbts_pkg::KIND_WRITE);
        can_go     = r_d_vld && (is_write || r_phase != 2'd0 ||
                                 r_credits < sbts_pkg::FIFO_FULL);
        d_last     = is_write || r_d.near || r_phase == 2'd3;
        d_done     = can_go && d_last;
        credit_inc = can_go && !is_write && r_phase == 2'd0;
        ram_en     = can_go && (!is_write || r_d.wr_ok);
        n_phase    = r_phase;
        if (can_go) begin
            n_phase = d_last ? 2'd0 : r_phase + 2'd1;
        end
        case (r_phase)
            2'd0: begin rd_x = r_d.x0; rd_y = r_d.y0; end
            2'd1: begin rd_x = r_d.x1; rd_y = r_d.y0; end
            2'd2: begin rd_x = r_d.x0; rd_y = r_d.y1; end
            2'd3: begin rd_x = r_d.x1; rd_y = r_d.y1; end
            default: begin rd_x = r_d.x0; rd_y = r_d.y0; end
        endcase
        n_tag.vld  = can_go && !is_write;
        n_tag.slot = r_phase;
        n_tag.last = d_last;
        n_tag.fill = r_d.near;
        n_tag.wx2  = r_d.wx2;
        n_tag.wy2  = r_d.wy2;
    end

    sbts_ram #(
        .WIDTH (sbts_pkg::TEXEL_W),
        .DEPTH (sbts_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (is_write),
        .i_addr  ({rd_y, rd_x}),
        .i_wdata (r_d.texel),
        .o_rdata (ram_q)
    );

    // Handshake between pipeline stages
    always_comb begin
        d_take  = !r_d_vld || d_done;
        c_take  = !r_c_vld || d_take;
        b_take  = !r_b_vld || c_take;
        a_take  = !r_a_vld || b_take;
        o_ready = a_take;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_phase <= 2'd0;
            r_tag   <= '0;
        end else begin
            if (a_take) r_a_vld <= i_valid;
            if (b_take) r_b_vld <= r_a_vld;
            if (c_take) r_c_vld <= r_b_vld;
            if (d_take) r_d_vld <= r_c_vld;
            r_phase <= n_phase;
            r_tag   <= n_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_take) r_a <= i_data;
        if (b_take) r_b <= n_b;
        if (c_take) r_c <= n_c;
        if (d_take) r_d <= n_d;
    end

    // Gather the four neighbors; nearest fills every slot with its one texel
    sbts_pkg::t_texel r_g [4];
    sbts_pkg::t_wt    r_gwx2, r_gwy2;
    logic             r_gv;

    always_ff @(posedge i_clk) begin
        if (r_tag.vld) begin
            if (r_tag.fill) begin
                for (int k = 0; k < 4; k++) begin
                    r_g[k] <= ram_q;
                end
            end else begin
                r_g[r_tag.slot] <= ram_q;
            end
            if (r_tag.last) begin
                r_gwx2 <= r_tag.wx2;
                r_gwy2 <= r_tag.wy2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gv <= 1'b0;
        end else begin
            r_gv <= r_tag.vld && r_tag.last;
        end
    end

    // Horizontal blend
    sbts_pkg::t_wt  wx1;
    sbts_pkg::t_mix mx_r1 [sbts_pkg::NUM_CHAN];
    sbts_pkg::t_mix mx_r2 [sbts_pkg::NUM_CHAN];
    sbts_pkg::t_mix r_mx_r1 [sbts_pkg::NUM_CHAN];
    sbts_pkg::t_mix r_mx_r2 [sbts_pkg::NUM_CHAN];
    sbts_pkg::t_wt  r_mx_wy2;
    logic           r_mx_vld;

    always_comb begin
        wx1 = sbts_pkg::ONE_Q16 - r_gwx2;
        for (int c = 0; c < sbts_pkg::NUM_CHAN; c++) begin
            mx_r1[c] = sbts_pkg::t_mix'(
                sbts_pkg::t_mixp'(r_g[0][c*sbts_pkg::CHAN_W +: sbts_pkg::CHAN_W]) *
                sbts_pkg::t_mixp'(wx1) +
                sbts_pkg::t_mixp'(r_g[1][c*sbts_pkg::CHAN_W +: sbts_pkg::CHAN_W]) *
                sbts_pkg::t_mixp'(r_gwx2));
            mx_r2[c] = sbts_pkg::t_mix'(
                sbts_pkg::t_mixp'(r_g[2][c*sbts_pkg::CHAN_W +: sbts_pkg::CHAN_W]) *
                sbts_pkg::t_mixp'(wx1) +
                sbts_pkg::t_mixp'(r_g[3][c*sbts_pkg::CHAN_W +: sbts_pkg::CHAN_W]) *
                sbts_pkg::t_mixp'(r_gwx2));
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_gv) begin
            r_mx_r1  <= mx_r1;
            r_mx_r2  <= mx_r2;
            r_mx_wy2 <= r_gwy2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mx_vld <= 1'b0;
        end else begin
            r_mx_vld <= r_gv;
        end
    end

    // Vertical blend with rounding
    sbts_pkg::t_wt    wy1;
    sbts_pkg::t_acc   acc [sbts_pkg::NUM_CHAN];
    sbts_pkg::t_chan  ch  [sbts_pkg::NUM_CHAN];
    sbts_pkg::t_out_item pix;

    always_comb begin
        wy1 = sbts_pkg::ONE_Q16 - r_mx_wy2;
        for (int c = 0; c < sbts_pkg::NUM_CHAN; c++) begin
            acc[c] = sbts_pkg::t_acc'(r_mx_r1[c]) * sbts_pkg::t_acc'(wy1) +
                     sbts_pkg::t_acc'(r_mx_r2[c]) * sbts_pkg::t_acc'(r_mx_wy2) +
                     sbts_pkg::RND_ACC;
            ch[c]  = acc[c][32 +: sbts_pkg::CHAN_W];
        end
        pix.out_red   = ch[0];
        pix.out_green = ch[1];
        pix.out_blue  = ch[2];
        pix.out_alpha = ch[3];
    end

    // Result queue
    sbts_pkg::t_out_item r_fifo [sbts_pkg::FIFO_DEPTH];

    assign push    = r_mx_vld;
    assign o_valid = (r_fcnt != '0);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_fifo[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) r_fifo[r_wptr] <= pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr    <= '0;
            r_rptr    <= '0;
            r_fcnt    <= '0;
            r_credits <= '0;
        end else begin
            if (push) r_wptr <= r_wptr + sbts_pkg::t_fptr'(1);
            if (pop)  r_rptr <= r_rptr + sbts_pkg::t_fptr'(1);
            r_fcnt    <= r_fcnt + sbts_pkg::t_fcnt'(push) - sbts_pkg::t_fcnt'(pop);
            r_credits <= r_credits + sbts_pkg::t_fcnt'(credit_inc) - sbts_pkg::t_fcnt'(pop);
        end
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the smoothed bilinear texture sampler. Writes and
// samples go in over a valid/ready channel with random gaps. Results come back
// under random back-pressure. A scoreboard keeps its own copy of the texel
// store and the registers and predicts each sampled pixel. Before every sample
// the texels it will touch are written first, so no empty entry is ever read.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_SHOWN     = 10;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int NUM_PHASES    = 10;

    // No register lives at this index
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    sbts_pkg::t_in_item  i_data = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    sbts_pkg::t_out_item o_data;
    logic                i_cfg_we = 1'b0;
    logic [1:0]          i_cfg_idx = sbts_pkg::CFG_WIDTH;
    logic [8:0]          i_cfg_data = '0;

    smoothed_bilinear_texture_sampler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Shadow copy of the block's registers and texel store
    logic [8:0]        cfg_width  = 9'd256;
    logic [8:0]        cfg_height = 9'd256;
    logic              cfg_mode   = sbts_pkg::MODE_SMOOTH;
    sbts_pkg::t_texel  texel_mem [0:sbts_pkg::STORE_DEPTH-1];
    bit                texel_written [0:sbts_pkg::STORE_DEPTH-1];

    sbts_pkg::t_out_item pending_pixels [$];
    int          fail_count = 0;
    int          shown_count = 0;
    int          idle_cycles = 0;
    int          tx_count = 0;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;

    typedef struct {
        int i0;
        int i1;
        int frac;
    } t_axis;

    function automatic int eff_dim(logic [8:0] r, int maxv);
        if (r == 0) return 1;
        if (r > maxv) return maxv;
        return int'(r);
    endfunction

    function automatic int texel_addr(int x, int y);
        return y * sbts_pkg::MAX_WIDTH + x;
    endfunction

    // Neighbor indexes and fraction along one axis for the current mode
    function automatic t_axis axis_taps(logic [16:0] coord, int size);
        t_axis  a;
        longint c;
        longint scaled;
        longint p;
        c = (coord > sbts_pkg::ONE_Q16) ? longint'(sbts_pkg::ONE_Q16) : longint'(coord);
        a.frac = 0;
        if (cfg_mode == sbts_pkg::MODE_NEAREST) begin
            a.i0 = int'((c * (size - 1) + 32768) >> 16);
            if (a.i0 > size - 1) a.i0 = size - 1;
            a.i1 = a.i0;
        end else begin
            scaled = c * (size - 1);
            a.i0 = 0;
            if (scaled >= 32768) begin
                p = scaled - 32768;
                a.i0 = int'(p >> 16);
                a.frac = int'(p & 65535);
            end
            if (a.i0 > size - 1) a.i0 = size - 1;
            a.i1 = (a.i0 + 1 > size - 1) ? size - 1 : a.i0 + 1;
        end
        return a;
    endfunction

    // t*t*(3-2t), Q0.16 in and out
    function automatic longint smooth_weight(int t);
        longint tt;
        tt = longint'(t) * t;
        return (tt * (longint'(196608) - 2 * longint'(t)) + (longint'(1) << 31)) >> 32;
    endfunction

    function automatic sbts_pkg::t_out_item predict_pixel(logic [16:0] u, logic [16:0] v);
        sbts_pkg::t_out_item r;
        t_axis               ax;
        t_axis               ay;
        sbts_pkg::t_texel    t11, t21, t12, t22;
        longint              wx1, wx2, wy1, wy2, r1, r2, val;
        logic [15:0]         ch [4];
        ax  = axis_taps(u, eff_dim(cfg_width, sbts_pkg::MAX_WIDTH));
        ay  = axis_taps(v, eff_dim(cfg_height, sbts_pkg::MAX_HEIGHT));
        t11 = texel_mem[texel_addr(ax.i0, ay.i0)];
        t21 = texel_mem[texel_addr(ax.i1, ay.i0)];
        t12 = texel_mem[texel_addr(ax.i0, ay.i1)];
        t22 = texel_mem[texel_addr(ax.i1, ay.i1)];
        wx2 = smooth_weight(ax.frac);
        wy2 = smooth_weight(ay.frac);
        wx1 = 65536 - wx2;
        wy1 = 65536 - wy2;
        for (int c = 0; c < sbts_pkg::NUM_CHAN; c++) begin
            if (cfg_mode == sbts_pkg::MODE_NEAREST) begin
                ch[c] = t11[sbts_pkg::CHAN_W*c +: sbts_pkg::CHAN_W];
            end else begin
                r1  = longint'(t11[sbts_pkg::CHAN_W*c +: sbts_pkg::CHAN_W]) * wx1
                    + longint'(t21[sbts_pkg::CHAN_W*c +: sbts_pkg::CHAN_W]) * wx2;
                r2  = longint'(t12[sbts_pkg::CHAN_W*c +: sbts_pkg::CHAN_W]) * wx1
                    + longint'(t22[sbts_pkg::CHAN_W*c +: sbts_pkg::CHAN_W]) * wx2;
                val = (r1 * wy1 + r2 * wy2 + (longint'(1) << 31)) >> 32;
                if (val > 65535) val = 65535;
                ch[c] = val[15:0];
            end
        end
        r.out_red   = ch[0];
        r.out_green = ch[1];
        r.out_blue  = ch[2];
        r.out_alpha = ch[3];
        return r;
    endfunction

    // Update the shadow store or queue the expected pixel for one transaction
    function automatic void apply_item(sbts_pkg::t_in_item it);
        int addr;
        if (it.kind == sbts_pkg::KIND_WRITE) begin
            if (it.pixel_x < eff_dim(cfg_width, sbts_pkg::MAX_WIDTH) &&
                it.pixel_y < eff_dim(cfg_height, sbts_pkg::MAX_HEIGHT)) begin
                addr = texel_addr(it.pixel_x, it.pixel_y);
                texel_mem[addr] = {it.wr_alpha & sbts_pkg::CHAN_KEEP,
                                   it.wr_blue & sbts_pkg::CHAN_KEEP,
                                   it.wr_green & sbts_pkg::CHAN_KEEP,
                                   it.wr_red & sbts_pkg::CHAN_KEEP};
                texel_written[addr] = 1'b1;
            end
        end else begin
            pending_pixels.push_back(predict_pixel(it.tex_u, it.tex_v));
        end
    endfunction

    function automatic logic [15:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [16:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return 17'd0;
            1:       return sbts_pkg::ONE_Q16;
            2:       return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic sbts_pkg::t_in_item make_write(int x, int y);
        sbts_pkg::t_in_item it;
        it.kind     = sbts_pkg::KIND_WRITE;
        it.pixel_x  = 8'(x);
        it.pixel_y  = 8'(y);
        it.wr_red   = rand_chan();
        it.wr_green = rand_chan();
        it.wr_blue  = rand_chan();
        it.wr_alpha = rand_chan();
        it.tex_u    = 17'($urandom);
        it.tex_v    = 17'($urandom);
        return it;
    endfunction

    function automatic sbts_pkg::t_in_item make_flat_write(int x, int y, logic [15:0] val);
        sbts_pkg::t_in_item it;
        it = make_write(x, y);
        it.wr_red   = val;
        it.wr_green = val;
        it.wr_blue  = val;
        it.wr_alpha = val;
        return it;
    endfunction

    function automatic sbts_pkg::t_in_item make_sample(logic [16:0] u, logic [16:0] v);
        sbts_pkg::t_in_item it;
        it = make_write($urandom_range(0, 255), $urandom_range(0, 255));
        it.kind  = sbts_pkg::KIND_SAMPLE;
        it.tex_u = u;
        it.tex_v = v;
        return it;
    endfunction

    // One input transaction: random gap, hold valid until accepted
    task automatic send_item(sbts_pkg::t_in_item it);
        int gap;
        if ($urandom_range(0, 39) == 0) tx_burst = ~tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 12);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        apply_item(it);
        tx_count++;
    endtask

    // Write any texel the sample will read that holds nothing yet, then sample
    task automatic sample_at(logic [16:0] u, logic [16:0] v);
        t_axis ax;
        t_axis ay;
        int    x;
        int    y;
        ax = axis_taps(u, eff_dim(cfg_width, sbts_pkg::MAX_WIDTH));
        ay = axis_taps(v, eff_dim(cfg_height, sbts_pkg::MAX_HEIGHT));
        for (int j = 0; j < 4; j++) begin
            x = j[0] ? ax.i1 : ax.i0;
            y = j[1] ? ay.i1 : ay.i0;
            if (!texel_written[texel_addr(x, y)]) send_item(make_write(x, y));
        end
        send_item(make_sample(u, v));
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [8:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            sbts_pkg::CFG_WIDTH:  cfg_width  = data;
            sbts_pkg::CFG_HEIGHT: cfg_height = data;
            sbts_pkg::CFG_MODE:   cfg_mode   = data[0];
            default:    ;
        endcase
    endtask

    task automatic set_config(logic [8:0] w, logic [8:0] h, logic mode);
        cfg_write(sbts_pkg::CFG_WIDTH, w);
        cfg_write(sbts_pkg::CFG_HEIGHT, h);
        cfg_write(sbts_pkg::CFG_MODE, {8'($urandom), mode});
    endtask

    // Stop sending, wait out every pixel, then let in-flight writes settle
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        send_item(make_flat_write(0, 0, 16'h0000));
        send_item(make_flat_write(255, 255, 16'hFFFF));
        send_item(make_flat_write(1, 0, 16'hFFFF));
        sample_at(17'd0, 17'd0);
        sample_at(sbts_pkg::ONE_Q16, sbts_pkg::ONE_Q16);
        sample_at(17'h1FFFF, 17'h10001);
        sample_at(17'd32768, 17'd32768);
        sample_at(17'd65535, 17'd1);
        drain();
    endtask

    task automatic test_size_edges();
        // Zero width acts as one, oversized height as the maximum
        set_config(9'd0, 9'd511, sbts_pkg::MODE_NEAREST);
        cfg_write(CFG_UNUSED, 9'($urandom));
        send_item(make_write(1, 0));
        sample_at(sbts_pkg::ONE_Q16, sbts_pkg::ONE_Q16);
        sample_at(17'd0, 17'd0);
        sample_at(17'h1FFFF, 17'd32768);
        drain();
        set_config(9'd2, 9'd2, sbts_pkg::MODE_SMOOTH);
        send_item(make_write(2, 1));
        send_item(make_write(0, 2));
        sample_at(17'd0, 17'd0);
        sample_at(17'd32768, 17'd32768);
        sample_at(17'd49152, 17'd16384);
        sample_at(sbts_pkg::ONE_Q16, 17'd0);
        drain();
    endtask

    task automatic test_random();
        int w;
        int h;
        int pick;
        int start;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: set_config(9'd256, 9'd256, sbts_pkg::MODE_SMOOTH);
                1: set_config(9'd1, 9'd1, sbts_pkg::MODE_NEAREST);
                2: set_config(9'd0, 9'd0, sbts_pkg::MODE_SMOOTH);
                3: set_config(9'd511, 9'd511, sbts_pkg::MODE_NEAREST);
                4: set_config(9'd2, 9'd2, sbts_pkg::MODE_SMOOTH);
                5: set_config(9'd256, 9'd1, sbts_pkg::MODE_SMOOTH);
                6: set_config(9'd1, 9'd256, sbts_pkg::MODE_NEAREST);
                7: set_config(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                              1'($urandom_range(0, 1)));
                default: set_config(9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)),
                                    1'($urandom_range(0, 1)));
            endcase
            w = eff_dim(cfg_width, sbts_pkg::MAX_WIDTH);
            h = eff_dim(cfg_height, sbts_pkg::MAX_HEIGHT);
            tx_burst = ($urandom_range(0, 3) == 0);
            start = tx_count;
            // Count every transaction, including the texel fills before a sample
            while (tx_count - start < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    sample_at(rand_coord(), rand_coord());
                end else if (pick < 85) begin
                    send_item(make_write($urandom_range(0, w - 1), $urandom_range(0, h - 1)));
                end else begin
                    // May land outside the image and be dropped
                    send_item(make_write($urandom_range(0, 255), $urandom_range(0, 255)));
                end
            end
            drain();
        end
    endtask

    // Result side: random stalls, check each transaction against the oldest pixel
    initial begin : result_checker
        int                  stall;
        sbts_pkg::t_out_item want;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 49) == 0) rx_burst = ~rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                @(negedge i_clk);
                i_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            if (pending_pixels.size() == 0) begin
                fail_count++;
                if (shown_count < MAX_SHOWN) begin
                    shown_count++;
                    $display("unexpected result: r=%h g=%h b=%h a=%h",
                             o_data.out_red, o_data.out_green,
                             o_data.out_blue, o_data.out_alpha);
                end
            end else begin
                want = pending_pixels.pop_front();
                if (o_data.out_red !== want.out_red || o_data.out_green !== want.out_green ||
                    o_data.out_blue !== want.out_blue ||
                    o_data.out_alpha !== want.out_alpha) begin
                    fail_count++;
                    if (shown_count < MAX_SHOWN) begin
                        shown_count++;
                        $display("pixel mismatch: exp r=%h g=%h b=%h a=%h, got r=%h g=%h b=%h a=%h",
                                 want.out_red, want.out_green, want.out_blue, want.out_alpha,
                                 o_data.out_red, o_data.out_green,
                                 o_data.out_blue, o_data.out_alpha);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_size_edges();
        test_random();
        drain();
        if (fail_count == 0 && pending_pixels.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
